[rtl/core/bcte_pkg.sv]
// bcte_pkg: shared types and constants of the block cache tag engine
// no dependencies
package bcte_pkg;

	localparam int unsigned Entries    = 16;
	localparam int unsigned IdxW       = $clog2(Entries);
	localparam int unsigned EntryBytes = 65536;
	localparam int unsigned QDepth     = 2;

	typedef enum logic [1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_FILL   = 2'd1,
		CMD_WRITE  = 2'd2,
		CMD_INVALL = 2'd3
	} cmd_t;

	// classified request handed from front to back
	typedef struct packed {
		cmd_t        cmd;
		logic [7:0]  device_id;
		logic [63:0] start_sector;
		logic [31:0] sector_total;
		logic        fits;
		logic        start_ovf;
	} req_t;

	typedef struct packed {
		logic       hit;
		logic       cacheable;
		logic [3:0] entry_index;
		logic [4:0] invalidated;
	} rsp_t;

endpackage

[rtl/core/bcte_front.sv]
// bcte_front: accepts requests, computes size fit and range overflow, queues them
// depends on bcte_pkg
module bcte_front import bcte_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  cmd,
	input  logic [7:0]  device_id,
	input  logic [63:0] start_sector,
	input  logic [31:0] sector_total,
	input  logic [15:0] sector_bytes,
	output logic        req_valid,
	output req_t        req,
	input  logic        req_take
);

	req_t                 mem_q [QDepth];
	logic [0:0]           wr_q, rd_q;
	logic [1:0]           cnt_q;
	logic [47:0]          prod;
	req_t                 cls;

	// classify the incoming request
	always_comb begin
		prod              = 48'(sector_total) * 48'(sector_bytes);
		cls.cmd           = cmd_t'(cmd);
		cls.device_id     = device_id;
		cls.start_sector  = start_sector;
		cls.sector_total  = sector_total;
		cls.fits          = (sector_total != '0) && (sector_bytes != '0) &&
		                    (prod <= 48'(EntryBytes));
		cls.start_ovf     = start_sector > (64'hFFFF_FFFF_FFFF_FFFF - 64'(sector_total));
	end

	assign full      = (cnt_q == 2'(QDepth));
	assign req_valid = (cnt_q != '0);
	assign req       = mem_q[rd_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_q] <= cls;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) wr_q <= wr_q + 1'b1;
			if (req_take) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + 2'(push && !full) - 2'(req_take);
		end
	end

endmodule

[rtl/core/bcte_back.sv]
// bcte_back: scans the tag store one entry per cycle and executes commands
// depends on bcte_pkg
module bcte_back import bcte_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  req_t req,
	output logic req_take,
	output logic empty,
	input  logic pop,
	output rsp_t rsp
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_DONE = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t            state_q;
	logic [Entries-1:0] valid_q;
	logic [7:0]        dev_q   [Entries];
	logic [63:0]       start_q [Entries];
	logic [31:0]       count_q [Entries];
	logic [63:0]       age_q   [Entries];
	logic [63:0]       clock_q;
	req_t              cur_q;
	logic [IdxW-1:0]   idx_q;
	logic              found_q;
	logic [IdxW-1:0]   best_q;
	logic [63:0]       best_age_q;
	logic              inv_found_q;
	logic [4:0]        ninv_q;
	rsp_t              rsp_q;
	logic              last;
	logic              tag_hit;
	logic              overlap;
	logic [63:0]       a_end, b_end;

	assign last     = (idx_q == IdxW'(Entries - 1));
	assign req_take = (state_q == ST_IDLE) && req_valid;
	assign empty    = (state_q != ST_OUT);
	assign rsp      = rsp_q;

	// compare of the current entry against the request
	always_comb begin
		tag_hit = valid_q[idx_q] && dev_q[idx_q] == cur_q.device_id &&
		          start_q[idx_q] == cur_q.start_sector &&
		          count_q[idx_q] == cur_q.sector_total;
		a_end   = start_q[idx_q] + 64'(count_q[idx_q]);
		b_end   = cur_q.start_sector + 64'(cur_q.sector_total);
		overlap = valid_q[idx_q] && dev_q[idx_q] == cur_q.device_id &&
		          ((start_q[idx_q] > 64'hFFFF_FFFF_FFFF_FFFF - 64'(count_q[idx_q])) ||
		           cur_q.start_ovf ||
		           (start_q[idx_q] < b_end && cur_q.start_sector < a_end));
	end

	// tag payload store
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && cur_q.cmd == CMD_LOOKUP && cur_q.fits &&
		    !found_q && tag_hit) begin
			age_q[idx_q] <= clock_q + 64'd1;
		end
		if (state_q == ST_DONE && cur_q.cmd == CMD_FILL && cur_q.fits) begin
			dev_q[best_q]   <= cur_q.device_id;
			start_q[best_q] <= cur_q.start_sector;
			count_q[best_q] <= cur_q.sector_total;
			age_q[best_q]   <= clock_q + 64'd1;
		end
		if (state_q == ST_SCAN && cur_q.cmd == CMD_INVALL) begin
			dev_q[idx_q]   <= '0;
			start_q[idx_q] <= '0;
			count_q[idx_q] <= '0;
			age_q[idx_q]   <= '0;
		end
		if (req_take) cur_q <= req;
	end

	// sequencer, valid bits and scan bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			clock_q     <= '0;
			idx_q       <= '0;
			found_q     <= 1'b0;
			best_q      <= '0;
			best_age_q  <= '0;
			inv_found_q <= 1'b0;
			ninv_q      <= '0;
			rsp_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q     <= ST_SCAN;
						idx_q       <= '0;
						found_q     <= 1'b0;
						best_q      <= '0;
						inv_found_q <= 1'b0;
						ninv_q      <= '0;
					end
				end
				ST_SCAN: begin
					case (cur_q.cmd)
						CMD_LOOKUP: begin
							if (cur_q.fits && !found_q && tag_hit) begin
								found_q <= 1'b1;
								best_q  <= idx_q;
								clock_q <= clock_q + 64'd1;
							end
						end
						CMD_FILL: begin
							if (!inv_found_q) begin
								if (!valid_q[idx_q]) begin
									inv_found_q <= 1'b1;
									best_q      <= idx_q;
								end else if (idx_q == '0 || age_q[idx_q] < best_age_q) begin
									best_q     <= idx_q;
									best_age_q <= age_q[idx_q];
								end
							end
						end
						CMD_WRITE: begin
							if (overlap) begin
								valid_q[idx_q] <= 1'b0;
								ninv_q         <= ninv_q + 5'd1;
							end
						end
						default: begin
							if (valid_q[idx_q]) ninv_q <= ninv_q + 5'd1;
							valid_q[idx_q] <= 1'b0;
						end
					endcase
					if (last) state_q <= ST_DONE;
					else      idx_q   <= idx_q + 1'b1;
				end
				ST_DONE: begin
					rsp_q.cacheable   <= cur_q.fits && cur_q.cmd != CMD_INVALL;
					rsp_q.hit         <= cur_q.cmd == CMD_LOOKUP && found_q;
					rsp_q.invalidated <= (cur_q.cmd == CMD_WRITE || cur_q.cmd == CMD_INVALL)
					                     ? ninv_q : 5'd0;
					rsp_q.entry_index <= '0;
					if ((cur_q.cmd == CMD_LOOKUP && found_q) ||
					    (cur_q.cmd == CMD_FILL && cur_q.fits)) begin
						rsp_q.entry_index <= 4'(best_q);
					end
					if (cur_q.cmd == CMD_FILL && cur_q.fits) begin
						valid_q[best_q] <= 1'b1;
						clock_q         <= clock_q + 64'd1;
					end
					if (cur_q.cmd == CMD_INVALL) clock_q <= '0;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (pop) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/block_cache_tag_engine_top.sv]
// block_cache_tag_engine_top: top level of the block cache tag engine
// depends on bcte_pkg, bcte_front, bcte_back
//
// usage
// requests enter through a queue port: an item is taken when push is high
// and full is low. a two deep request queue sits in front of the engine,
// so up to two requests may wait while one is being worked on.
// results leave through a queue port: while empty is low the oldest result
// is on hit, cacheable, entry_index and invalidated, and it is taken when
// pop is high. each request gives exactly one result.
// flow: with the engine idle a request leaves the queue, the tag store is
// scanned one entry per cycle through the single entry compare port, and
// the result is committed. the next request starts once the result is
// popped, so only one request is worked on at a time.
// reset clears all valid bits and the age clock, so the cache starts empty.
// a stalled receiver holds the result and the engine waits; new requests
// still queue until full is raised.
module block_cache_tag_engine_top import bcte_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  cmd,
	input  logic [7:0]  device_id,
	input  logic [63:0] start_sector,
	input  logic [31:0] sector_total,
	input  logic [15:0] sector_bytes,
	output logic        empty,
	input  logic        pop,
	output logic        hit,
	output logic        cacheable,
	output logic [3:0]  entry_index,
	output logic [4:0]  invalidated
);

	logic req_valid, req_take;
	req_t req;
	rsp_t rsp;

	// request side
	bcte_front u_front (
		.clk, .arst_n, .push, .full, .cmd, .device_id, .start_sector,
		.sector_total, .sector_bytes, .req_valid, .req, .req_take
	);

	// tag engine
	bcte_back u_back (
		.clk, .arst_n, .req_valid, .req, .req_take, .empty, .pop, .rsp
	);

	assign hit         = rsp.hit;
	assign cacheable   = rsp.cacheable;
	assign entry_index = rsp.entry_index;
	assign invalidated = rsp.invalidated;

`ifndef NO_ASSERTIONS
	// a hit only comes with a cacheable request
	a_hit_cach: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && hit) |-> cacheable) else $error("hit without cacheable");
	// a hit never reports invalidations
	a_hit_inv: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && hit) |-> invalidated == 5'd0) else $error("hit with invalidations");
	// the engine only takes a request while no result waits
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		req_take |-> empty) else $error("request taken while result pending");
`endif

endmodule

[tb/sv/tb_block_cache_tag_engine_top.sv]
// testbench for block_cache_tag_engine_top: directed and random cache commands,
// checked beat by beat against an in-bench tag store predictor
// depends on bcte_pkg and block_cache_tag_engine_top
module tb_block_cache_tag_engine_top;
	import bcte_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		cmd_t        op;
		logic [7:0]  dev;
		logic [63:0] lba;
		logic [31:0] cnt;
		logic [15:0] ssz;
	} blk_req_t;

	typedef struct {
		logic       hit;
		logic       cacheable;
		logic [3:0] entry_index;
		logic [4:0] invalidated;
	} blk_rsp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [1:0]  cmd = '0;
	logic [7:0]  device_id = '0;
	logic [63:0] start_sector = '0;
	logic [31:0] sector_total = '0;
	logic [15:0] sector_bytes = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic        hit;
	logic        cacheable;
	logic [3:0]  entry_index;
	logic [4:0]  invalidated;

	blk_req_t pending_reqs[$];
	blk_rsp_t expected_rsps[$];
	int       mismatches = 0;
	bit       stim_done = 1'b0;
	bit       hold_off = 1'b0;

	// predictor copy of the tag store
	bit          tag_valid[Entries];
	logic [7:0]  tag_dev[Entries];
	logic [63:0] tag_lba[Entries];
	logic [31:0] tag_cnt[Entries];
	logic [63:0] tag_age[Entries];
	logic [63:0] lru_clock;

	block_cache_tag_engine_top DUT (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void clear_tags();
		for (int i = 0; i < Entries; i++) begin
			tag_valid[i] = 1'b0;
			tag_dev[i] = '0;
			tag_lba[i] = '0;
			tag_cnt[i] = '0;
			tag_age[i] = '0;
		end
		lru_clock = '0;
	endfunction

	// apply one request to the predicted store and return its result
	function automatic blk_rsp_t predict_cache(blk_req_t r);
		blk_rsp_t    o;
		bit          fits;
		int          victim;
		logic [63:0] end_a, end_b;
		o = '{1'b0, 1'b0, 4'd0, 5'd0};
		fits = r.cnt != 0 && r.ssz != 0 &&
			({32'd0, r.cnt} * {48'd0, r.ssz}) <= 64'(EntryBytes);
		case (r.op)
			CMD_LOOKUP: begin
				o.cacheable = fits;
				if (fits)
					for (int i = 0; i < Entries; i++)
						if (tag_valid[i] && tag_dev[i] == r.dev && tag_lba[i] == r.lba &&
								tag_cnt[i] == r.cnt) begin
							lru_clock++;
							tag_age[i] = lru_clock;
							o.hit = 1'b1;
							o.entry_index = 4'(i);
							break;
						end
			end
			CMD_FILL: begin
				o.cacheable = fits;
				if (fits) begin
					victim = 0;
					for (int i = 0; i < Entries; i++) begin
						if (!tag_valid[i]) begin
							victim = i;
							break;
						end
						if (tag_age[i] < tag_age[victim]) victim = i;
					end
					tag_dev[victim] = r.dev;
					tag_lba[victim] = r.lba;
					tag_cnt[victim] = r.cnt;
					lru_clock++;
					tag_age[victim] = lru_clock;
					tag_valid[victim] = 1'b1;
					o.entry_index = 4'(victim);
				end
			end
			CMD_WRITE: begin
				o.cacheable = fits;
				for (int i = 0; i < Entries; i++) begin
					if (!tag_valid[i] || tag_dev[i] != r.dev) continue;
					end_a = tag_lba[i] + {32'd0, tag_cnt[i]};
					end_b = r.lba + {32'd0, r.cnt};
					// wrapping end counts as overlap
					if (tag_lba[i] > ~64'd0 - {32'd0, tag_cnt[i]} ||
							r.lba > ~64'd0 - {32'd0, r.cnt} ||
							(tag_lba[i] < end_b && r.lba < end_a)) begin
						tag_valid[i] = 1'b0;
						o.invalidated++;
					end
				end
			end
			default: begin
				for (int i = 0; i < Entries; i++)
					if (tag_valid[i]) o.invalidated++;
				clear_tags();
			end
		endcase
		return o;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	function automatic void add_req(cmd_t op, logic [7:0] dev, logic [63:0] lba,
			logic [31:0] cnt, logic [15:0] ssz);
		blk_req_t r;
		r.op = op;
		r.dev = dev;
		r.lba = lba;
		r.cnt = cnt;
		r.ssz = ssz;
		pending_reqs.push_back(r);
	endfunction

	// driver: bursts and gaps
	int burst_left = 0, gap_left = 0;
	always @(posedge clk) begin
		blk_req_t r;
		if (arst_n) begin
			if (push && !full) begin
				r = pending_reqs.pop_front();
				expected_rsps.push_back(predict_cache(r));
			end
			if (push && full) begin
				// beat still offered
			end else if (hold_off || pending_reqs.size() == 0) begin
				push <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				push <= 1'b0;
			end else begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
				end
				burst_left--;
				r = pending_reqs[0];
				push <= 1'b1;
				cmd <= r.op;
				device_id <= r.dev;
				start_sector <= r.lba;
				sector_total <= r.cnt;
				sector_bytes <= r.ssz;
			end
		end
	end

	// monitor and receiver stall pattern
	int stall_phase = 0;
	always @(posedge clk) begin
		blk_rsp_t e;
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_rsps.size() == 0) begin
					report_mismatch("unexpected beat", 1, 0);
				end else begin
					e = expected_rsps.pop_front();
					if (hit !== e.hit) report_mismatch("hit", hit, e.hit);
					if (cacheable !== e.cacheable)
						report_mismatch("cacheable", cacheable, e.cacheable);
					if (entry_index !== e.entry_index)
						report_mismatch("entry_index", entry_index, e.entry_index);
					if (invalidated !== e.invalidated)
						report_mismatch("invalidated", invalidated, e.invalidated);
				end
			end
			stall_phase = (stall_phase + 1) % 97;
			if (stall_phase < 30) pop <= 1'b1;
			else if (stall_phase < 50) pop <= 1'b0;
			else pop <= ($urandom_range(0, 2) != 0);
		end
	end

	function automatic cmd_t rand_op();
		case ($urandom_range(0, 19))
			0: return CMD_INVALL;
			1, 2, 3, 4: return CMD_WRITE;
			5, 6, 7, 8, 9, 10, 11: return CMD_FILL;
			default: return CMD_LOOKUP;
		endcase
	endfunction

	// stimulus
	initial begin
		logic [63:0] lba_pool[8];
		logic [31:0] cnt;
		logic [15:0] ssz;
		logic [63:0] lba;
		logic [7:0]  dev;
		clear_tags();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: size edges, wrap ranges, every command
		add_req(CMD_LOOKUP, 8'd0, 64'd0, 32'd0, 16'd512);
		add_req(CMD_FILL, 8'd1, 64'd100, 32'd128, 16'd512);
		add_req(CMD_FILL, 8'd1, 64'd200, 32'd129, 16'd512);
		add_req(CMD_FILL, 8'd2, 64'd0, 32'd1, 16'd0);
		add_req(CMD_FILL, 8'hFF, ~64'd0, 32'hFFFF_FFFF, 16'hFFFF);
		add_req(CMD_FILL, 8'hFF, ~64'd0, 32'd1, 16'hFFFF);
		add_req(CMD_FILL, 8'd3, 64'd0, 32'd65536, 16'd1);
		add_req(CMD_LOOKUP, 8'd1, 64'd100, 32'd128, 16'd512);
		add_req(CMD_LOOKUP, 8'd1, 64'd100, 32'd127, 16'd512);
		add_req(CMD_LOOKUP, 8'hFF, ~64'd0, 32'd1, 16'hFFFF);
		add_req(CMD_WRITE, 8'd1, 64'd227, 32'd1, 16'd512);
		add_req(CMD_WRITE, 8'd1, 64'd228, 32'd0, 16'd512);
		add_req(CMD_WRITE, 8'd1, 64'd150, 32'd0, 16'd0);
		add_req(CMD_WRITE, 8'hFF, 64'd5, 32'd1, 16'd512);
		add_req(CMD_WRITE, 8'd3, ~64'd0, 32'hFFFF_FFFF, 16'hFFFF);
		add_req(CMD_INVALL, 8'hAA, 64'hAAAA_5555_AAAA_5555, 32'h5555_AAAA, 16'h55AA);
		// fill past capacity to exercise lru
		for (int i = 0; i < 18; i++) add_req(CMD_FILL, 8'd4, 64'(i * 8), 32'd8, 16'd512);
		add_req(CMD_LOOKUP, 8'd4, 64'd16, 32'd8, 16'd512);
		add_req(CMD_FILL, 8'd4, 64'd999, 32'd8, 16'd512);
		add_req(CMD_INVALL, 8'd0, 64'd0, 32'd0, 16'd0);

		// pause until drained
		wait (pending_reqs.size() == 0);
		hold_off = 1'b1;
		wait (expected_rsps.size() == 0);
		hold_off = 1'b0;

		// random: a small pool of ranges so lookups hit and writes overlap
		for (int i = 0; i < 8; i++)
			lba_pool[i] = ($urandom_range(0, 9) == 0) ? ~64'd0 - $urandom_range(0, 64)
				: 64'($urandom_range(0, 2000));
		for (int n = 0; n < 1050; n++) begin
			dev = 8'($urandom_range(0, 3));
			lba = lba_pool[$urandom_range(0, 7)] + 64'($urandom_range(0, 1) * 8);
			cnt = 32'(8 << $urandom_range(0, 2));
			ssz = 16'd512;
			if ($urandom_range(0, 9) == 0) begin
				// noise over full field widths
				dev = 8'($urandom);
				lba = {$urandom, $urandom};
				cnt = $urandom;
				ssz = 16'($urandom);
			end else if ($urandom_range(0, 9) == 0) begin
				cnt = 32'($urandom_range(0, 300));
				ssz = 16'($urandom_range(0, 1024));
			end
			add_req(rand_op(), dev, lba, cnt, ssz);
		end
		stim_done = 1'b1;
	end

	// end of run
	initial begin
		wait (stim_done && pending_reqs.size() == 0 && expected_rsps.size() == 0);
		repeat (100) @(posedge clk);
		if (mismatches == 0 && expected_rsps.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#4ms;
		$display("end of test: mismatches");
		$finish;
	end
endmodule

[block_cache_tag_engine_top.f]
rtl/core/bcte_pkg.sv
rtl/core/bcte_front.sv
rtl/core/bcte_back.sv
rtl/core/block_cache_tag_engine_top.sv
tb/sv/tb_block_cache_tag_engine_top.sv
